// ===== hw/rtl/bqr_pkg.sv =====
// Package of shared types and constants for the base quality recalibrator.
`timescale 1ns / 1ps
package bqr_pkg;

   localparam int ThrWidth = 15;
   localparam int QualWidth = 8;
   localparam int IdxWidth = 7;
   localparam int IntWidth = 17;
   localparam int IntLimit = 65535;

   localparam logic CmdRecal = 1'b0;
   localparam logic CmdLoad = 1'b1;

   localparam logic StatusOk = 1'b0;
   localparam logic StatusEmpty = 1'b1;

   // One classified job handed from the front part to the back part.
   typedef struct packed {
      logic                 is_load;
      logic                 in_range;
      logic [IdxWidth-1:0]  cycle;
      logic [IdxWidth-1:0]  entry;
      logic [ThrWidth-1:0]  threshold;
      logic [QualWidth-1:0] quality;
      logic                 purity;
      logic [IntWidth-1:0]  int_a;
      logic [IntWidth-1:0]  int_c;
      logic [IntWidth-1:0]  int_g;
      logic [IntWidth-1:0]  int_t;
      logic                 base_n;
   } job_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_SCAN,
      ST_READ,
      ST_DONE
   } back_state_type;

endpackage

// ===== hw/rtl/bqr_front.sv =====
// Front part: accepts items and queues classified jobs.
`timescale 1ns / 1ps
module bqr_front
   import bqr_pkg::*;
#(
   parameter int CYCLES = 128,
   parameter int DEPTH = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  job_type         in_job,
   output logic            q_valid,
   input  logic            q_ready,
   output job_type         q_job
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   job_type             fifo_ff [DEPTH];
   job_type             cls_job;
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]       cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready = (cnt_ff != (PtrW+1)'(DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign q_job    = fifo_ff[rd_ff];

   // Classification: note whether the cycle index lies below the number of cycles.
   always_comb begin
      cls_job = in_job;
      cls_job.in_range = (32'(in_job.cycle) < CYCLES);
   end

   // Pointer and count updates.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ff] <= cls_job;
      end
   end

endmodule

// ===== hw/rtl/bqr_back.sv =====
// Back part: purity predictor, divider, table scan and table writes.
`timescale 1ns / 1ps
module bqr_back
   import bqr_pkg::*;
#(
   parameter int CYCLES = 128,
   parameter int BINS = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  job_type              q_job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [QualWidth-1:0] out_quality,
   output logic [IdxWidth-1:0]  out_bin,
   output logic                 out_status
);

   localparam int CycW = (CYCLES > 1) ? $clog2(CYCLES) : 1;
   localparam int BinW = $clog2(BINS);
   localparam int AddrW = CycW + BinW;
   localparam int CntW = BinW + 1;
   localparam int SumW = 21;
   localparam int NumW = 30;
   localparam int TblDepth = 1 << AddrW;
   localparam int CntDepth = 1 << CycW;

   logic [ThrWidth-1:0]  thr_mem [TblDepth];
   logic [QualWidth-1:0] qual_mem [TblDepth];
   logic [CntW-1:0]      cnt_mem [CntDepth];

   back_state_type       state_ff, state_in;
   job_type              job_ff;
   logic signed [SumW-1:0] hi_ff, sum_ff;
   logic [NumW-1:0]      rem_ff;
   logic [SumW:0]        den_ff;
   logic [6:0]           quo_ff;
   logic [2:0]           dstep_ff;
   logic [CntW-1:0]      idx_ff, cnt_ff;
   logic [CntW-1:0]      cnt_rd_ff;
   logic [CycW-1:0]      clr_ff;
   logic [ThrWidth-1:0]  thr_rd_ff;
   logic [QualWidth-1:0] qual_rd_ff;
   logic                 rd_pending_ff;
   logic                 out_valid_ff;
   logic [QualWidth-1:0] oq_ff;
   logic [IdxWidth-1:0]  ob_ff;
   logic                 os_ff;

   logic [CycW-1:0]      cyc;
   logic [BinW-1:0]      ent;
   logic [AddrW-1:0]     rd_addr;
   logic                 match, last, load_ok, cnt_grow;
   logic [15:0]          value;

   assign cyc = CycW'(job_ff.cycle);
   assign ent = BinW'(job_ff.entry);
   assign value = job_ff.purity ? {1'b0, quo_ff, 8'd0} : {job_ff.quality, 8'd0};
   assign match = ({1'b0, value} <= {2'b0, thr_rd_ff});
   assign last = (idx_ff == cnt_ff - 1'b1);
   assign load_ok = job_ff.is_load && job_ff.in_range && (32'(job_ff.entry) < BINS);
   assign cnt_grow = (CntW'(job_ff.entry) + 1'b1) > cnt_rd_ff;

   // Channel clamp and shift.
   function automatic logic signed [17:0] clampv(logic [IntWidth-1:0] v);
      logic signed [17:0] s;
      s = 18'(signed'(v));
      if (s > 18'sd65535) s = 18'sd65535;
      if (s < -18'sd65535) s = -18'sd65535;
      return s;
   endfunction

   logic signed [17:0] ca, cc, cg, ct, lo, hi;
   logic signed [SumW-1:0] sum_c, hi_c;
   always_comb begin
      ca = clampv(job_ff.int_a);
      cc = clampv(job_ff.int_c);
      cg = clampv(job_ff.int_g);
      ct = clampv(job_ff.int_t);
      lo = ca; hi = ca;
      if (cc < lo) lo = cc;
      if (cg < lo) lo = cg;
      if (ct < lo) lo = ct;
      if (cc > hi) hi = cc;
      if (cg > hi) hi = cg;
      if (ct > hi) hi = ct;
      sum_c = SumW'(ca) + SumW'(cc) + SumW'(cg) + SumW'(ct);
      hi_c = SumW'(hi);
      if (lo <= 0) begin
         hi_c  = SumW'(hi) - SumW'(lo) + SumW'(1);
         sum_c = sum_c - (SumW'(lo) - SumW'(1)) * SumW'(4);
      end
   end

   // Numerator 200*hi - 49*sum, from registered operands.
   logic signed [NumW:0] num_c;
   assign num_c = (NumW+1)'(hi_ff) * (NumW+1)'(200) - (NumW+1)'(sum_ff) * (NumW+1)'(49);

   // Restoring division step for the seven quotient bits.
   logic [NumW:0] trial;
   assign trial = {1'b0, rem_ff} - ((NumW+1)'(den_ff) << dstep_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE: if (q_valid) state_in = ST_PREP;
         ST_PREP: begin
            if (job_ff.is_load || !job_ff.in_range || cnt_rd_ff == '0) begin
               state_in = ST_DONE;
            end else if (job_ff.purity) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_DIV:  if (dstep_ff == 3'd0) state_in = ST_SCAN;
         ST_SCAN: if (!rd_pending_ff && (match || last)) state_in = ST_READ;
         ST_READ: if (!rd_pending_ff) state_in = ST_DONE;
         ST_DONE: if (!out_valid_ff || out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      q_ready = (state_ff == ST_IDLE);
      rd_addr = {cyc, idx_ff[BinW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_DONE && (!out_valid_ff || out_ready)) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Entry counts per cycle: zeroed by a pass after reset, read as a job is taken.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         cnt_mem[clr_ff] <= '0;
      end else if (state_ff == ST_PREP && load_ok && cnt_grow) begin
         cnt_mem[cyc] <= CntW'(job_ff.entry) + 1'b1;
      end
      cnt_rd_ff <= cnt_mem[CycW'(q_job.cycle)];
   end

   // Table memories, written by loads and read with a registered port.
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP && load_ok) begin
         thr_mem[{cyc, ent}]  <= job_ff.threshold;
         qual_mem[{cyc, ent}] <= job_ff.quality;
      end
      thr_rd_ff  <= thr_mem[rd_addr];
      qual_rd_ff <= qual_mem[rd_addr];
   end

   // Datapath sequencing.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            job_ff <= q_job;
         end
         ST_PREP: begin
            hi_ff <= hi_c;
            sum_ff <= sum_c;
            cnt_ff <= cnt_rd_ff;
            idx_ff <= '0;
            dstep_ff <= 3'd7;
            quo_ff <= '0;
            rd_pending_ff <= 1'b1;
         end
         ST_DIV: begin
            if (dstep_ff == 3'd7) begin
               den_ff <= (SumW+1)'(sum_ff) << 1;
               rem_ff <= (num_c <= 0) ? '0 : NumW'(num_c);
               dstep_ff <= 3'd6;
            end else begin
               if (!trial[NumW]) begin
                  rem_ff <= trial[NumW-1:0];
                  quo_ff[dstep_ff] <= 1'b1;
               end
               if (dstep_ff != 3'd0) dstep_ff <= dstep_ff - 1'b1;
            end
            rd_pending_ff <= 1'b1;
         end
         ST_SCAN: begin
            if (rd_pending_ff) begin
               rd_pending_ff <= 1'b0;
            end else if (!(match || last)) begin
               idx_ff <= idx_ff + 1'b1;
               rd_pending_ff <= 1'b1;
            end else begin
               rd_pending_ff <= 1'b1;
            end
         end
         ST_READ: begin
            rd_pending_ff <= 1'b0;
         end
         ST_DONE: begin
            if (!out_valid_ff || out_ready) begin
               if (job_ff.is_load) begin
                  oq_ff <= '0; ob_ff <= '0; os_ff <= StatusOk;
               end else if (!job_ff.in_range || cnt_ff == '0) begin
                  oq_ff <= '0; ob_ff <= '0; os_ff <= StatusEmpty;
               end else begin
                  os_ff <= StatusOk;
                  ob_ff <= IdxWidth'(idx_ff);
                  oq_ff <= job_ff.base_n ? '0 :
                           (qual_rd_ff == '0 ? QualWidth'(1) : qual_rd_ff);
               end
            end
         end
         default: ;
      endcase
   end

   assign out_valid = out_valid_ff;
   assign out_quality = oq_ff;
   assign out_bin = ob_ff;
   assign out_status = os_ff;

endmodule

// ===== hw/rtl/base_quality_recalibrator.sv =====
// Top level of the base quality recalibrator.
//  channel | direction | content
//  req     | in        | command (tuser); cycle, intensities, quality, N flag, load entry
//  rsp     | out       | new_quality, bin_chosen, status
//  csr     | in        | purity_mode
// A purity-mode base passes through the serial divider and then scans the bins with the
// one-port table read; a quality-mode base skips the divider and scans the bins, and a
// load or an empty-table base goes straight to its result.
// Reset is synchronous; the mode resets to purity, and a pass afterwards zeroes the
// entry count of every cycle index before the first job is taken.
// The job queue of two lets the front accept while the back part works or stalls.
`timescale 1ns / 1ps
module base_quality_recalibrator
   import bqr_pkg::*;
#(
   parameter int CYCLES = 128,
   parameter int BINS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command
   input  logic        req_tuser,
   // cycle_index[6:0], intensity_a/c/g/t, orig_quality, base_is_n, entry_index,
   // entry_threshold, entry_quality[113:106]; zero padding
   input  logic [119:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_quality[7:0], bin_chosen[14:8], status[15]
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic    mode_ff;
   job_type in_job, q_job;
   logic    q_valid, q_ready;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b1;
      else if (csr_valid) mode_ff <= csr_data;
   end

   // Unpack one transfer into a job.
   always_comb begin
      in_job.is_load   = (req_tuser == CmdLoad);
      in_job.in_range  = 1'b0;
      in_job.cycle     = req_tdata[6:0];
      in_job.int_a     = req_tdata[23:7];
      in_job.int_c     = req_tdata[40:24];
      in_job.int_g     = req_tdata[57:41];
      in_job.int_t     = req_tdata[74:58];
      in_job.base_n    = req_tdata[83];
      in_job.entry     = req_tdata[90:84];
      in_job.threshold = req_tdata[105:91];
      in_job.quality   = (req_tuser == CmdLoad) ? req_tdata[113:106] : req_tdata[82:75];
      in_job.purity    = mode_ff;
   end

   bqr_front #(.CYCLES(CYCLES), .DEPTH(2)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_job(in_job), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
   );

   bqr_back #(.CYCLES(CYCLES), .BINS(BINS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_job(q_job), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_quality(rsp_tdata[7:0]), .out_bin(rsp_tdata[14:8]),
      .out_status(rsp_tdata[15])
   );

endmodule

// ===== hw/rtl/bqr_checker.sv =====
// Port checker for the base quality recalibrator, with its bind.
`timescale 1ns / 1ps
module bqr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_ready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[14:0] == 15'd0)
      else $error("empty status with payload");
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind base_quality_recalibrator bqr_checker u_chk (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .csr_ready(csr_ready)
);

// ===== tb/base_quality_recalibrator_tb.sv =====
// Self-checking testbench for the base quality recalibrator.
`timescale 1ns / 1ps
module base_quality_recalibrator_tb;
   import bqr_pkg::*;

   localparam int NumCycles = 128;
   localparam int NumBins = 128;
   localparam int SettleCycles = 400;

   typedef struct {
      logic                 command;
      logic [IdxWidth-1:0]  cycle_index;
      logic [IntWidth-1:0]  int_a;
      logic [IntWidth-1:0]  int_c;
      logic [IntWidth-1:0]  int_g;
      logic [IntWidth-1:0]  int_t;
      logic [QualWidth-1:0] orig_quality;
      logic                 base_is_n;
      logic [IdxWidth-1:0]  entry_index;
      logic [ThrWidth-1:0]  entry_threshold;
      logic [QualWidth-1:0] entry_quality;
   } base_item_type;

   typedef struct {
      logic [QualWidth-1:0] new_quality;
      logic [IdxWidth-1:0]  bin_chosen;
      logic                 status;
   } recal_result_type;

   // Mirror of the calibration tables and the queue of predicted results.
   class recal_scoreboard;
      logic                 purity_mode;
      logic [ThrWidth-1:0]  thresholds[NumCycles*NumBins];
      logic [QualWidth-1:0] qualities[NumCycles*NumBins];
      int                   loaded[NumCycles];
      recal_result_type     pending[$];
      int                   errors;

      function new();
         purity_mode = 1'b1;
         errors = 0;
         foreach (loaded[i]) loaded[i] = 0;
      endfunction

      function longint clamp_intensity(logic [IntWidth-1:0] raw);
         longint v;
         v = longint'($signed(raw));
         if (v > IntLimit) v = IntLimit;
         if (v < -IntLimit) v = -IntLimit;
         return v;
      endfunction

      // Purity value: round(100*max/sum - 25) done with integer division.
      function int purity_value(base_item_type it);
         longint ch[4];
         longint lo, hi, sum, num;
         ch[0] = clamp_intensity(it.int_a);
         ch[1] = clamp_intensity(it.int_c);
         ch[2] = clamp_intensity(it.int_g);
         ch[3] = clamp_intensity(it.int_t);
         lo = ch[0];
         hi = ch[0];
         sum = ch[0];
         for (int i = 1; i < 4; i++) begin
            if (ch[i] < lo) lo = ch[i];
            if (ch[i] > hi) hi = ch[i];
            sum += ch[i];
         end
         // Shift everything up so that the smallest channel becomes one.
         if (lo <= 0) begin
            lo -= 1;
            hi -= lo;
            sum -= 4 * lo;
         end
         if (sum <= 0) return 0;
         num = 200 * hi - 49 * sum;
         if (num <= 0) return 0;
         return int'(num / (2 * sum));
      endfunction

      function void note_request(base_item_type it);
         recal_result_type r;
         int value, count, bin, k;
         logic [QualWidth-1:0] q;
         r.new_quality = '0;
         r.bin_chosen = '0;
         r.status = StatusOk;
         if (it.command == CmdLoad) begin
            k = it.cycle_index * NumBins + it.entry_index;
            thresholds[k] = it.entry_threshold;
            qualities[k] = it.entry_quality;
            if (it.entry_index + 1 > loaded[it.cycle_index])
               loaded[it.cycle_index] = it.entry_index + 1;
         end else if (loaded[it.cycle_index] == 0) begin
            r.status = StatusEmpty;
         end else begin
            value = purity_mode ? purity_value(it) : int'(it.orig_quality);
            count = loaded[it.cycle_index];
            k = it.cycle_index * NumBins;
            bin = count - 1;
            for (int i = 0; i < count; i++) begin
               if (value * 256 <= int'(thresholds[k + i])) begin
                  bin = i;
                  break;
               end
            end
            q = qualities[k + bin];
            if (it.base_is_n) q = '0;
            else if (q == '0) q = 8'd1;
            r.new_quality = q;
            r.bin_chosen = bin[IdxWidth-1:0];
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic [15:0] data);
         recal_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: result with none expected, actual %h", $realtime, data);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[7:0] !== e.new_quality) begin
            $display("%0t: new_quality expected %0d actual %0d",
                     $realtime, e.new_quality, data[7:0]);
            errors++;
         end
         if (data[14:8] !== e.bin_chosen) begin
            $display("%0t: bin_chosen expected %0d actual %0d",
                     $realtime, e.bin_chosen, data[14:8]);
            errors++;
         end
         if (data[15] !== e.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $realtime, e.status, data[15]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser = 1'b0;
   logic [119:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   recal_scoreboard recal_sb;
   bit              quiet_tail = 1'b0;
   // Entries written so far per cycle; loads only extend a table without gaps.
   int              table_fill[NumCycles];

   always #5 clock = ~clock;

   base_quality_recalibrator #(
      .CYCLES(NumCycles),
      .BINS  (NumBins)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   function automatic logic [119:0] pack_item(base_item_type it);
      return {6'd0, it.entry_quality, it.entry_threshold, it.entry_index, it.base_is_n,
              it.orig_quality, it.int_t, it.int_g, it.int_c, it.int_a,
              it.cycle_index};
   endfunction

   // Send one item, with an occasional idle burst first; valid stays high afterwards.
   task automatic send_item(base_item_type it);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tuser <= it.command;
      req_tdata <= pack_item(it);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      recal_sb.note_request(it);
      if (it.command == CmdLoad && it.entry_index >= table_fill[it.cycle_index])
         table_fill[it.cycle_index] = it.entry_index + 1;
      @(negedge clock);
   endtask

   task automatic write_mode(logic mode);
      csr_data <= mode;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      recal_sb.purity_mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (recal_sb.pending.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   function automatic base_item_type blank_item();
      base_item_type it;
      it.command = CmdRecal;
      it.cycle_index = '0;
      it.int_a = '0;
      it.int_c = '0;
      it.int_g = '0;
      it.int_t = '0;
      it.orig_quality = '0;
      it.base_is_n = 1'b0;
      it.entry_index = '0;
      it.entry_threshold = '0;
      it.entry_quality = '0;
      return it;
   endfunction

   function automatic logic [IntWidth-1:0] random_intensity();
      case ($urandom_range(0, 3))
         0: return IntWidth'($urandom);
         1: return IntWidth'($urandom_range(0, 2000));
         2: return IntWidth'(-$signed($urandom_range(0, 500)));
         default: return IntWidth'($urandom_range(20000, 65535));
      endcase
   endfunction

   // Random item: mostly bases on a few busy cycles, loads that extend or rewrite tables.
   function automatic base_item_type random_item();
      base_item_type it;
      int cyc;
      it = blank_item();
      cyc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NumCycles - 1)
                                        : $urandom_range(0, 11);
      it.cycle_index = IdxWidth'(cyc);
      it.int_a = random_intensity();
      it.int_c = random_intensity();
      it.int_g = random_intensity();
      it.int_t = random_intensity();
      it.orig_quality = QualWidth'($urandom);
      it.base_is_n = ($urandom_range(0, 9) == 0);
      it.entry_threshold = ThrWidth'($urandom);
      if ($urandom_range(0, 1)) it.entry_threshold = ThrWidth'($urandom_range(0, 80 * 256));
      it.entry_quality = QualWidth'($urandom);
      if ($urandom_range(0, 9) == 0) it.entry_quality = '0;
      if ($urandom_range(0, 3) == 0 && table_fill[cyc] < NumBins) begin
         it.command = CmdLoad;
         // Extend the table by one entry or rewrite one that exists.
         it.entry_index = IdxWidth'((table_fill[cyc] == 0 || $urandom_range(0, 2) != 0)
                          ? table_fill[cyc] : int'($urandom_range(0, table_fill[cyc] - 1)));
      end else begin
         it.entry_index = IdxWidth'($urandom);
      end
      return it;
   endfunction

   // Result side stalls in random bursts until the quiet tail.
   initial begin
      forever begin
         @(negedge clock);
         if (reset || quiet_tail || $urandom_range(0, 7) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         recal_sb.check_response(rsp_tdata);
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      base_item_type it;
      recal_sb = new();
      foreach (table_fill[i]) table_fill[i] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table, loads at the extremes, special bases.
      it = blank_item();
      send_item(it);
      it.cycle_index = 7'd127;
      send_item(it);
      for (int i = 0; i < 4; i++) begin
         it = blank_item();
         it.command = CmdLoad;
         it.cycle_index = 7'd127;
         it.entry_index = IdxWidth'(i);
         it.entry_threshold = (i == 3) ? 15'h7FFF : 15'(i * 20 * 256);
         it.entry_quality = (i == 1) ? 8'd0 : 8'(40 + i * 70);
         send_item(it);
      end
      it = blank_item();
      it.cycle_index = 7'd127;
      it.int_a = 17'h10000;
      it.int_c = 17'h0FFFF;
      it.int_g = 17'h1FFFF;
      it.int_t = 17'h00000;
      send_item(it);
      it.int_a = 17'd65535;
      it.int_c = '0;
      it.int_g = '0;
      it.int_t = '0;
      send_item(it);
      it.int_a = 17'd1000;
      it.int_c = 17'd1000;
      it.int_g = 17'd1000;
      it.int_t = 17'd1000;
      send_item(it);
      it.int_a = 17'd1500;
      it.int_c = 17'd500;
      send_item(it);
      it.base_is_n = 1'b1;
      send_item(it);
      drain_results();

      // Quality mode: predictor is the original quality.
      write_mode(1'b0);
      it = blank_item();
      it.cycle_index = 7'd127;
      it.orig_quality = 8'd0;
      send_item(it);
      it.orig_quality = 8'd20;
      send_item(it);
      it.orig_quality = 8'd255;
      send_item(it);
      it.orig_quality = 8'd20;
      it.base_is_n = 1'b1;
      send_item(it);
      drain_results();

      // Random phases across both modes.
      for (int phase = 0; phase < 4; phase++) begin
         if (phase > 0) write_mode(phase[0]);
         for (int n = 0; n < 275; n++) begin
            if (phase == 3 && n == 200) quiet_tail = 1'b1;
            send_item(random_item());
         end
         if (phase < 3) drain_results();
      end

      drain_results();
      if (recal_sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== base_quality_recalibrator.f =====
hw/rtl/bqr_pkg.sv
hw/rtl/bqr_front.sv
hw/rtl/bqr_back.sv
hw/rtl/base_quality_recalibrator.sv
hw/rtl/bqr_checker.sv
tb/base_quality_recalibrator_tb.sv
